/* hdl/rsti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsti_pkg
// Shared types, character codes and digit helpers for the radix string parser.
// ----------------------------------------------------------------------------
package rsti_pkg;

    typedef enum logic [1:0] {
        MODE_BIN = 2'd0,
        MODE_OCT = 2'd1,
        MODE_DEC = 2'd2,
        MODE_HEX = 2'd3
    } radix_mode_t;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;

    localparam logic [4:0] DIGIT_NONE = 5'd16;
    localparam logic [5:0] COUNT_MAX  = 6'd32;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    // 0..15 for a hex digit character, DIGIT_NONE otherwise
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd16;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                d = c - CHAR_ZERO;
            else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
                d = c - CHAR_UC_A + 8'd10;
            else if (c >= CHAR_LC_A && c <= CHAR_LC_F)
                d = c - CHAR_LC_A + 8'd10;
            return d[4:0];
        end
    endfunction

    function automatic logic [4:0] base_of(input radix_mode_t m);
        logic [4:0] b;
        begin
            unique case (m)
                MODE_BIN: b = 5'd2;
                MODE_OCT: b = 5'd8;
                MODE_DEC: b = 5'd10;
                MODE_HEX: b = 5'd16;
                default:  b = 5'd10;
            endcase
            return b;
        end
    endfunction

    // bits per digit for power-of-two bases
    function automatic logic [2:0] bits_of(input radix_mode_t m);
        logic [2:0] b;
        begin
            unique case (m)
                MODE_BIN: b = 3'd1;
                MODE_OCT: b = 3'd3;
                MODE_DEC: b = 3'd0;
                MODE_HEX: b = 3'd4;
                default:  b = 3'd0;
            endcase
            return b;
        end
    endfunction

endpackage

/* hdl/rsti_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsti_in_stage
// Input register: captures one character per cycle while in_ready is high.
// ----------------------------------------------------------------------------
module rsti_in_stage
    import rsti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic       advance,
    output logic       stage_valid,
    output char_item_t stage_item
);

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       accept;

    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.char_code <= char_code;
            item_reg.last_char <= last_char;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

/* hdl/rsti_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsti_accum
// String state and per-character accumulate; forms the final value on the
// last character.
// ----------------------------------------------------------------------------
module rsti_accum
    import rsti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  char_item_t         item,
    input  radix_mode_t        mode,
    output logic signed [31:0] result
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        first_reg;
    logic        first_next;
    logic        neg_reg;
    logic        neg_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;

    logic [4:0]  digit;
    logic [4:0]  base;
    logic [4:0]  d_eff;
    logic        is_sign;
    logic        neg_upd;
    logic [31:0] acc_scaled;
    logic [31:0] acc_upd;
    logic [5:0]  cnt_upd;
    logic [8:0]  shift;
    logic [31:0] power;

    assign digit   = digit_of(item.char_code);
    assign base    = base_of(mode);
    assign d_eff   = (digit < base) ? digit : 5'd0;
    assign is_sign = first_reg && (mode == MODE_DEC) && (item.char_code == CHAR_MINUS);

    always_comb
    begin
        neg_upd = neg_reg;
        if (first_reg)
        begin
            if (mode == MODE_DEC)
                neg_upd = neg_reg || is_sign;
            else
                neg_upd = (digit < base) && (digit >= (base >> 1));
        end
    end

    always_comb
    begin
        case (mode)
            MODE_BIN: acc_scaled = {acc_reg[30:0], 1'b0};
            MODE_OCT: acc_scaled = {acc_reg[28:0], 3'b000};
            MODE_DEC: acc_scaled = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
            MODE_HEX: acc_scaled = {acc_reg[27:0], 4'b0000};
            default:  acc_scaled = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
        endcase
    end

    assign acc_upd = is_sign ? acc_reg : acc_scaled + {27'd0, d_eff};
    assign cnt_upd = (is_sign || cnt_reg >= COUNT_MAX) ? cnt_reg : cnt_reg + 6'd1;

    // base^n for power-of-two bases, zero once it passes 2^31
    assign shift = {6'd0, bits_of(mode)} * {3'd0, cnt_upd};
    assign power = (shift < 9'd32) ? (32'd1 << shift[4:0]) : 32'd0;

    always_comb
    begin
        if (mode == MODE_DEC)
            result = neg_upd ? 32'd0 - acc_upd : acc_upd;
        else
            result = neg_upd ? acc_upd - power : acc_upd;
    end

    always_comb
    begin
        acc_next   = acc_reg;
        first_next = first_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        if (fire)
        begin
            if (item.last_char)
            begin
                acc_next   = 32'd0;
                first_next = 1'b1;
                neg_next   = 1'b0;
                cnt_next   = 6'd0;
            end
            else
            begin
                acc_next   = acc_upd;
                first_next = 1'b0;
                neg_next   = neg_upd;
                cnt_next   = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 32'd0;
            first_reg <= 1'b1;
            neg_reg   <= 1'b0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            acc_reg   <= acc_next;
            first_reg <= first_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_MAX)
        else $error("digit count above saturation");

    a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> (acc_reg == 32'd0 && cnt_reg == 6'd0 && !neg_reg))
        else $error("string state not cleared at string start");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last_char |=> first_reg)
        else $error("state not returned to string start after last char");

    a_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.last_char |=> !first_reg)
        else $error("string start flag set mid-string");
`endif

endmodule

/* hdl/radix_string_to_integer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_to_integer
// ASCII digit string to signed 32-bit integer in base 2, 8, 10 or 16.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, set by the single accumulate stage,
// except while a final character waits on a stalled result receiver.
// Input register, accumulate logic, output register; input ready depends
// on output ready only when the staged character ends a string.
// Reset: async active low; clears string state, radix_mode returns to base 10.
module radix_string_to_integer
    import rsti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] parsed_value
);

    radix_mode_t        mode_reg;
    logic               stage_valid;
    char_item_t         stage_item;
    logic               advance;
    logic               fire;
    logic signed [31:0] result;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_DEC;
        else if (cfg_wr_en)
            mode_reg <= radix_mode_t'(cfg_wr_data);
    end

    assign advance = stage_valid && (!stage_item.last_char || !out_valid_reg || out_ready);
    assign fire    = advance;

    rsti_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .last_char   (last_char),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    rsti_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (stage_item),
        .mode   (mode_reg),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && stage_item.last_char)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && stage_item.last_char)
            value_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = value_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(fire && stage_item.last_char))
        else $error("pending result overwritten");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && stage_item.last_char |=> out_valid_reg)
        else $error("last character gave no result");

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !stage_item.last_char |-> in_ready)
        else $error("input stalled behind a non-final character");
`endif

endmodule

/* verif/rsti_value_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsti_value_checker
// Watches the character and result channels of the radix string parser. It
// follows every accepted character with its own parser model and queues the
// value each completed string should produce. Each result transaction is
// compared against the oldest queued value.
// ----------------------------------------------------------------------------
module rsti_value_checker
    import rsti_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] parsed_value,
    output int                 fail_count,
    output int                 open_count
);

    radix_mode_t       mode_now;
    logic [31:0]       acc;
    logic              at_start;
    logic              negative;
    logic [5:0]        char_count;
    logic signed [31:0] expected_values[$];
    int                shown;

    function automatic logic [4:0] char_digit(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return 5'(c - CHAR_ZERO);
        if (c >= CHAR_UC_A && c <= CHAR_UC_F)
            return 5'(c - CHAR_UC_A + 8'd10);
        if (c >= CHAR_LC_A && c <= CHAR_LC_F)
            return 5'(c - CHAR_LC_A + 8'd10);
        return DIGIT_NONE;
    endfunction

    task automatic clear_string();
        acc        = 32'd0;
        at_start   = 1'b1;
        negative   = 1'b0;
        char_count = 6'd0;
    endtask

    task automatic absorb_char(input logic [7:0] c, input logic l);
        logic [31:0] base;
        logic [31:0] digit;
        logic [31:0] value;
        logic [31:0] power;
        int          shift;
        int          bits;
        logic        sign_char;
        begin
            sign_char = 1'b0;
            case (mode_now)
                MODE_BIN: begin base = 32'd2;  bits = 1; end
                MODE_OCT: begin base = 32'd8;  bits = 3; end
                MODE_DEC: begin base = 32'd10; bits = 0; end
                default:  begin base = 32'd16; bits = 4; end
            endcase
            digit = 32'(char_digit(c));
            if (at_start) begin
                if (mode_now == MODE_DEC) begin
                    if (c == CHAR_MINUS) begin
                        sign_char = 1'b1;
                        negative  = 1'b1;
                    end
                end else begin
                    negative = (digit < base) && (digit >= (base >> 1));
                end
                at_start = 1'b0;
            end
            if (!sign_char) begin
                if (digit >= base)
                    digit = 32'd0;
                acc = acc * base + digit;
                if (char_count < COUNT_MAX)
                    char_count = char_count + 6'd1;
            end
            if (l) begin
                value = acc;
                if (mode_now == MODE_DEC) begin
                    if (negative)
                        value = -value;
                end else if (negative) begin
                    shift = bits * int'(char_count);
                    power = (shift < 32) ? (32'd1 << shift) : 32'd0;
                    value = value - power;
                end
                expected_values.push_back(value);
                clear_string();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_now = MODE_DEC;
            clear_string();
            expected_values.delete();
            fail_count = 0;
            open_count = 0;
            shown      = 0;
        end else begin
            if (cfg_wr_en)
                mode_now = radix_mode_t'(cfg_wr_data);
            if (in_valid && in_ready)
                absorb_char(char_code, last_char);
            if (out_valid && out_ready) begin
                if (expected_values.size() == 0) begin
                    fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("%0t: unexpected result transaction, value %0d",
                                 $time, parsed_value);
                    end
                end else begin
                    if (parsed_value !== expected_values[0]) begin
                        fail_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("%0t: parsed_value mismatch, expected %0d got %0d",
                                     $time, expected_values[0], parsed_value);
                        end
                    end
                    void'(expected_values.pop_front());
                end
            end
            open_count = expected_values.size();
        end
    end

endmodule

/* verif/tb_radix_string_to_integer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_string_to_integer
// Drives character strings into the radix string parser in every base, with
// directed corner strings followed by random strings and noise, bursty input
// and a stalling result receiver. Checking is done by rsti_value_checker.
// ----------------------------------------------------------------------------
module tb_radix_string_to_integer;
    import rsti_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [1:0]         cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         char_code;
    logic               last_char;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] parsed_value;

    int fail_count;
    int open_count;
    int cycle_count = 0;
    int hold_req = 0;
    int burst_left = 0;
    int chars_sent = 0;

    always #5 clk = ~clk;

    radix_string_to_integer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value)
    );

    rsti_value_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .parsed_value (parsed_value),
        .fail_count   (fail_count),
        .open_count   (open_count)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: stall patterns, plus a long hold-off on request
    initial
    begin
        int seen_hold;
        int style;
        int seg;
        int k;
        seen_hold = 0;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req != seen_hold) begin
                seen_hold = hold_req;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            style = $urandom_range(0, 2);
            seg   = $urandom_range(8, 40);
            for (k = 0; k < seg; k++) begin
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (k % 3 == 0);
                endcase
                @(negedge clk);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            in_valid  <= 1'b1;
            char_code <= c;
            last_char <= l;
            do
                @(posedge clk);
            while (!in_ready);
            chars_sent++;
            @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        int k;
        begin
            for (k = 0; k < s.len(); k++)
                send_char(s[k], k == s.len() - 1);
        end
    endtask

    task automatic write_mode(input radix_mode_t m);
        begin
            in_valid <= 1'b0;
            wait (open_count == 0);
            repeat (4) @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= m;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            burst_left = 0;
        end
    endtask

    function automatic logic [7:0] pick_char(input radix_mode_t m);
        int base;
        int d;
        int pick;
        begin
            case (m)
                MODE_BIN: base = 2;
                MODE_OCT: base = 8;
                MODE_DEC: base = 10;
                default:  base = 16;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                d = $urandom_range(0, base - 1);
                if (d < 10)
                    return CHAR_ZERO + 8'(d);
                if ($urandom_range(0, 1) == 1)
                    return CHAR_UC_A + 8'(d - 10);
                return CHAR_LC_A + 8'(d - 10);
            end
            if (pick < 92)
                return CHAR_MINUS;
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic send_random_string(input radix_mode_t m);
        int len;
        int k;
        logic [7:0] c;
        begin
            len = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 40)
                                              : $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                if (k == 0 && m == MODE_DEC && $urandom_range(0, 3) == 0)
                    c = CHAR_MINUS;
                else
                    c = pick_char(m);
                send_char(c, k == len - 1);
            end
        end
    endtask

    initial
    begin
        radix_mode_t m;
        int phase;
        int phase_start;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = MODE_DEC;
        in_valid    = 1'b0;
        char_code   = 8'h00;
        last_char   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // base 10 from reset: sign handling, bad digits, extreme codes
        send_text("-");
        send_text("-9");
        send_text("1-");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        write_mode(MODE_BIN);
        send_text("1");
        send_text("01");
        write_mode(MODE_OCT);
        send_text("7");
        send_text("8");
        write_mode(MODE_HEX);
        send_text("fF");
        // sign taken in hex, string finished in base 10
        send_char(CHAR_NINE, 1'b0);
        write_mode(MODE_DEC);
        send_char(CHAR_NINE, 1'b1);
        write_mode(MODE_HEX);
        send_text("FFFFFFFFF");

        chars_sent = 0;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       m = MODE_BIN;
                1:       m = MODE_HEX;
                2:       m = MODE_OCT;
                3:       m = MODE_DEC;
                default: m = radix_mode_t'($urandom_range(0, 3));
            endcase
            write_mode(m);
            if (phase == 1 || phase == 5)
                hold_req++;
            phase_start = chars_sent;
            while (chars_sent - phase_start < 56)
                send_random_string(m);
        end

        in_valid <= 1'b0;
        wait (open_count == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
